[rtl/mpfe_pkg.sv]
// Package for the PWM fade engine: types, codes and helpers shared across files.
package mpfe_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SCAN_LIMIT = 8;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] LVL_MIN = 3'd0;
  localparam logic [2:0] LVL_MID = 3'd1;
  localparam logic [2:0] LVL_VAL = 3'd2;
  localparam logic [2:0] LVL_MAX = 3'd3;

  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [2:0] REG_TICK_PERIOD   = 3'd1;
  localparam logic [2:0] REG_MIN_DUTY      = 3'd2;
  localparam logic [2:0] REG_MID_DUTY      = 3'd3;
  localparam logic [2:0] REG_MAX_DUTY      = 3'd4;

  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_RISING  = 2'd1;
  localparam logic [1:0] DIR_FALLING = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic [15:0] start_duty;
    logic [15:0] end_duty;
    logic [23:0] duration_ms;
    logic [2:0]  level_select;
    logic [15:0] level_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [15:0] duty;
    logic        duty_write;
    logic        fade_done;
    logic [1:0]  direction;
    logic        all_done;
    logic        status;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the item
    logic div_start;  // begin ticks division
    logic div_step;   // one restoring step
    logic div2_start; // begin step division
    logic start_wr;   // commit a start
    logic scan_init;  // point scan at slot 0
    logic scan_step;  // process current slot
    logic emit_single;// single result of start/set/clear
    logic emit_all;   // all-done result
    logic clr_tick;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       start_bad;   // reject or out of range
    logic       ticks_zero;
    logic       ticking;
    logic       scan_end;    // current slot is the last scanned
    logic       any_active;
  } sts_t;

endpackage

[rtl/mpfe_ctrl.sv]
// Sequencer for the PWM fade engine.
module mpfe_ctrl import mpfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_DIV1  = 7'b0000100,
    S_DIV2  = 7'b0001000,
    S_WR    = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_ALL   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ctl = '0;
    case (state)
      S_IDLE: if (start) begin
        ctl.load = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        case (sts.op)
          OP_START: begin
            if (sts.start_bad) begin
              ctl.emit_single = 1'b1;
              state_next = S_IDLE;
            end else begin
              ctl.div_start = 1'b1;
              cnt_next = 5'd23;
              state_next = S_DIV1;
            end
          end
          OP_TICK: begin
            if (sts.ticking) begin
              ctl.scan_init = 1'b1;
              state_next = S_SCAN;
            end else begin
              state_next = S_IDLE;
            end
          end
          default: begin
            ctl.emit_single = 1'b1;
            ctl.clr_tick = (sts.op == OP_SET);
            state_next = S_IDLE;
          end
        endcase
      end
      S_DIV1: begin
        ctl.div_step = 1'b1;
        cnt_next = cnt - 5'd1;
        if (cnt == 5'd0) state_next = S_WR;
      end
      S_WR: begin
        // quotient of ticks ready; start second division unless zero
        if (sts.ticks_zero) begin
          ctl.start_wr = 1'b1;
          ctl.emit_single = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.div2_start = 1'b1;
          cnt_next = 5'd24;
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        // 24 steps, then commit once the last quotient bit is in
        if (cnt == 5'd0) begin
          ctl.start_wr = 1'b1;
          ctl.emit_single = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.div_step = 1'b1;
          cnt_next = cnt - 5'd1;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_end) state_next = S_ALL;
      end
      S_ALL: begin
        if (!sts.any_active) begin
          ctl.emit_all = 1'b1;
          ctl.clr_tick = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

endmodule

[rtl/mpfe_datapath.sv]
// Datapath for the PWM fade engine: channel state, divider, scan and result register.
module mpfe_datapath import mpfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic        done,
  output out_item_t   result
);

  logic [3:0]  channel_count;
  logic [9:0]  tick_period;
  logic [15:0] min_duty, mid_duty, max_duty;

  logic [23:0] rem   [CHANNELS];
  logic [15:0] stp   [CHANNELS];
  logic [15:0] fst   [CHANNELS];
  logic [15:0] fen   [CHANNELS];
  logic [15:0] cur   [CHANNELS];
  logic        ticking;

  in_item_t    it;
  logic [23:0] quo, rmd, dvs;
  logic [23:0] ticks;
  logic [CH_W-1:0] scan_ix;
  logic [3:0]  scan_n;
  logic        act;
  logic        ch_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 4'd8;
      tick_period <= 10'd10;
      min_duty <= 16'd0;
      mid_duty <= 16'd19200;
      max_duty <= 16'd38400;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[3:0];
        REG_TICK_PERIOD:   tick_period <= cfg_data[9:0];
        REG_MIN_DUTY:      min_duty <= cfg_data;
        REG_MID_DUTY:      mid_duty <= cfg_data;
        REG_MAX_DUTY:      max_duty <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ch_ok = ({1'b0, it.channel} < 4'(CHANNELS));

  always_comb begin
    scan_n = (channel_count == 4'd0) ? 4'd1 : channel_count;
    if (scan_n > 4'(SCAN_LIMIT)) scan_n = 4'(SCAN_LIMIT);
    if (scan_n > 4'(CHANNELS)) scan_n = 4'(CHANNELS);
  end

  assign sts.op = it.operation;
  assign sts.start_bad = !ch_ok || (it.start_duty == it.end_duty);
  assign sts.ticks_zero = (quo == 24'd0);
  assign sts.ticking = ticking;
  assign sts.scan_end = ({1'b0, scan_ix} == 4'(scan_n - 4'd1)) ||
                        (int'(scan_ix) == CHANNELS - 1);
  assign sts.any_active = act;

  // restoring divider, one quotient bit per cycle
  logic [24:0] trial;
  assign trial = {rmd, quo[23]} - {1'b0, dvs};

  logic [15:0] diff;
  assign diff = (it.start_duty > it.end_duty) ? it.start_duty - it.end_duty
                                               : it.end_duty - it.start_duty;

  // per-slot step for the current scan slot
  logic [23:0] r_new;
  logic [15:0] c_new;
  logic        moved, up, dn;
  always_comb begin
    up = fst[scan_ix] < fen[scan_ix];
    dn = fst[scan_ix] > fen[scan_ix];
    moved = (rem[scan_ix] != 24'd0) && (up || dn);
    r_new = moved ? rem[scan_ix] - 24'd1 : rem[scan_ix];
    c_new = dn ? cur[scan_ix] - stp[scan_ix] : cur[scan_ix] + stp[scan_ix];
  end

  // a later scanned slot still fading will emit after this one
  logic        later_busy;
  always_comb begin
    later_busy = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      if (j > int'(scan_ix) && j < int'(scan_n) && rem[j] != 24'd0) later_busy = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticking <= 1'b0;
      done <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        rem[i] <= '0; stp[i] <= '0; fst[i] <= '0; fen[i] <= '0; cur[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (ctl.load) it <= item;
      if (ctl.div_start) begin
        quo <= it.duration_ms;
        rmd <= '0;
        dvs <= {14'd0, (tick_period == 10'd0) ? 10'd1 : tick_period};
        ticks <= '0;
      end
      if (ctl.div2_start) begin
        ticks <= quo;
        quo <= {diff, 8'd0};
        rmd <= '0;
        dvs <= quo;
      end
      if (ctl.div_step) begin
        if (!trial[24]) begin
          rmd <= trial[23:0];
          quo <= {quo[22:0], 1'b1};
        end else begin
          rmd <= {rmd[22:0], quo[23]};
          quo <= {quo[22:0], 1'b0};
        end
      end
      if (ctl.start_wr) begin
        // second division ran on diff<<8, so drop the eight extra bits
        rem[it.channel] <= ticks;
        fst[it.channel] <= it.start_duty;
        fen[it.channel] <= it.end_duty;
        cur[it.channel] <= it.start_duty;
        stp[it.channel] <= (ticks == 24'd0) ? 16'd0 : 16'(quo >> 8);
        if (ticks != 24'd0) ticking <= 1'b1;
      end
      if (ctl.emit_single) begin
        done <= 1'b1;
        result <= '0;
        result.out_channel <= it.channel;
        result.last <= 1'b1;
        case (it.operation)
          OP_START: begin
            result.status <= sts.start_bad;
            if (!sts.start_bad) begin
              result.duty <= it.start_duty;
              result.duty_write <= 1'b1;
            end
          end
          OP_SET: begin
            result.status <= !ch_ok;
            if (ch_ok && it.level_select <= LVL_MAX) begin
              result.duty_write <= 1'b1;
              case (it.level_select)
                LVL_MIN: result.duty <= min_duty;
                LVL_MID: result.duty <= mid_duty;
                LVL_VAL: result.duty <= it.level_value;
                default: result.duty <= max_duty;
              endcase
            end
          end
          default: begin
            result.status <= !ch_ok;
            if (ch_ok) rem[it.channel] <= '0;
          end
        endcase
      end
      if (ctl.clr_tick) ticking <= 1'b0;
      if (ctl.scan_init) begin
        scan_ix <= '0;
        act <= 1'b0;
      end
      if (ctl.scan_step) begin
        rem[scan_ix] <= r_new;
        if (moved) cur[scan_ix] <= c_new;
        if (r_new != 24'd0) act <= 1'b1;
        if (rem[scan_ix] != 24'd0) begin
          done <= 1'b1;
          result <= '0;
          result.out_channel <= 3'(scan_ix);
          result.duty_write <= 1'b1;
          result.duty <= (r_new == 24'd0) ? fen[scan_ix] : c_new;
          if (r_new == 24'd0 && moved) begin
            result.fade_done <= 1'b1;
            result.direction <= dn ? DIR_FALLING : DIR_RISING;
          end
          // last when no later slot emits and no all-done follows
          result.last <= !later_busy && (act || r_new != 24'd0);
        end
        if (!sts.scan_end) scan_ix <= scan_ix + CH_W'(1);
      end
      if (ctl.emit_all) begin
        done <= 1'b1;
        result <= '0;
        result.all_done <= 1'b1;
        result.last <= 1'b1;
      end
    end
  end

endmodule

[rtl/multichannel_pwm_fade_engine.sv]
// Top level of the multichannel PWM fade engine.
//  channel  | signals                    | transfer
//  command  | start, busy, cmd           | start && !busy
//  result   | result_valid, result       | one cycle strobe
//  config   | cfg_we, cfg_index, cfg_data| cfg_we
// A start decodes, runs a 24-step serial division (duration by tick period),
// hands off and, unless that quotient is zero, runs a second 24-step division
// before the commit; a tick scans the slots, at most one result per cycle.
// Reset clears all channel state at once. The receiver cannot stall.
module multichannel_pwm_fade_engine import mpfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    cmd,
  output logic        result_valid,
  output out_item_t   result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ctl_t ctl;
  sts_t sts;

  mpfe_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .ctl);

  mpfe_datapath u_dp (
    .clk, .rst, .item(cmd), .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .ctl, .sts, .done(result_valid), .result
  );

`ifndef ASSERT_OFF
  a_no_start_when_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.all_done) |-> result.last)
    else $error("all-done not last");
  a_done_dir: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.fade_done) |-> (result.direction != DIR_NONE))
    else $error("fade done without direction");
`endif

endmodule
